[rtl/hyperslab_run_address_generator_unit_macros.svh]
// Assertion macros shared by the hyperslab run address generator RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef HYPERSLAB_RUN_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define HYPERSLAB_RUN_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define HRAG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hrag_pkg.sv]
// Package for the hyperslab run address generator: sizes, codes, payload types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package hrag_pkg;

  localparam int MAX_RANK  = 4;
  localparam int DIM_BITS  = 16;
  localparam int ADDR_BITS = 48;

  localparam int DIDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W = 3;
  localparam int EB_W   = 7;
  localparam int CFG_W  = 64;
  localparam int APB_AW = 6;
  localparam int PROD_W = ADDR_BITS + DIM_BITS;
  localparam int MAC_W  = PROD_W + 1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    REG_RANK  = 3'd0,
    REG_ELEM  = 3'd1,
    REG_DIMS  = 3'd2,
    REG_LOWER = 3'd3,
    REG_UPPER = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_NORUN = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    OP_MAC  = 1'b0,
    OP_MSUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_STA,
    S_STB,
    S_HIB,
    S_HIA,
    S_HIEND,
    S_OFA,
    S_OFEND,
    S_DEND,
    S_EMIT,
    S_CARRY,
    S_SRCEND
  } state_t;

  typedef struct packed {
    logic                 action;
    logic [ADDR_BITS-1:0] source_base;
    logic [ADDR_BITS-1:0] dest_base;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] run_source;
    logic [ADDR_BITS-1:0] run_dest;
    logic [ADDR_BITS-1:0] run_bytes;
    logic                 last_run;
  } rsp_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [EB_W-1:0]   elem_bytes;
    logic [CFG_W-1:0]  dim_sizes;
    logic [CFG_W-1:0]  lower;
    logic [CFG_W-1:0]  upper;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    alu_op_t              op;
    logic [ADDR_BITS-1:0] a;
    logic [DIM_BITS-1:0]  b;
    logic [ADDR_BITS-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] val;
    logic                 ovf;
  } alu_res_t;

  // Field of one dimension in a packed register; fields past the top read as zero.
  function automatic logic [DIM_BITS-1:0] dim_field(input logic [CFG_W-1:0] pk,
                                                    input int unsigned d);
    logic [CFG_W-1:0] sh;
    sh = pk >> (d * DIM_BITS);
    return sh[DIM_BITS-1:0];
  endfunction

endpackage

[rtl/hrag_regs.sv]
// APB-style configuration register file of the hyperslab run address generator.
// Depends on hrag_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps

module hrag_regs import hrag_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              cfg_we
);

  reg_idx_t idx;
  logic     wr;
  logic     hit;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_we = wr && hit;

  always_comb begin
    prdata = '0;
    hit    = 1'b1;
    unique case (idx)
      REG_RANK:  prdata = {{(CFG_W-RANK_W){1'b0}}, cfg.rank};
      REG_ELEM:  prdata = {{(CFG_W-EB_W){1'b0}}, cfg.elem_bytes};
      REG_DIMS:  prdata = cfg.dim_sizes;
      REG_LOWER: prdata = cfg.lower;
      REG_UPPER: prdata = cfg.upper;
      default:   hit    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rank       <= RANK_W'(1);
      cfg.elem_bytes <= EB_W'(4);
      cfg.dim_sizes  <= '0;
      cfg.lower      <= '0;
      cfg.upper      <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_RANK:  cfg.rank       <= pwdata[RANK_W-1:0];
        REG_ELEM:  cfg.elem_bytes <= pwdata[EB_W-1:0];
        REG_DIMS:  cfg.dim_sizes  <= pwdata;
        REG_LOWER: cfg.lower      <= pwdata;
        REG_UPPER: cfg.upper      <= pwdata;
        default: ;
      endcase
    end
  end

endmodule

[rtl/hrag_alu.sv]
// Shared multiply-add unit: c + a*b with overflow flag, or c - a*b modulo the address.
// One operation per cycle with a registered result. Depends on hrag_pkg.
`timescale 1ns / 1ps

module hrag_alu import hrag_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_res_t res
);

  logic [PROD_W-1:0]    prod;
  logic [MAC_W-1:0]     sum;
  logic [ADDR_BITS-1:0] diff;

  always_comb begin
    prod = PROD_W'(req.a) * PROD_W'(req.b);
    sum  = MAC_W'(prod) + MAC_W'(req.c);
    diff = req.c - prod[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= req.valid;
    end
    if (req.valid) begin
      if (req.op == OP_MAC) begin
        res.val <= sum[ADDR_BITS-1:0];
        res.ovf <= |sum[MAC_W-1:ADDR_BITS];
      end else begin
        res.val <= diff;
        res.ovf <= 1'b0;
      end
    end
  end

endmodule

[rtl/hrag_seq.sv]
// Sequencer of the hyperslab run address generator: slice setup, run issue, index carry.
// Drives the shared multiply-add unit; depends on hrag_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "hyperslab_run_address_generator_unit_macros.svh"

module hrag_seq import hrag_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     cfg_we,
  input  logic     req_valid,
  output logic     req_ready,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp,
  output alu_req_t alu_req,
  input  alu_res_t alu_res
);

  state_t state, state_next;

  logic                 active;
  logic                 ovf;
  status_t              code;
  logic [ADDR_BITS-1:0] sbase;
  logic [ADDR_BITS-1:0] dbase;
  logic [DIDX_W-1:0]    d;
  logic [DIDX_W-1:0]    run_level;
  logic [ADDR_BITS-1:0] run_length;
  logic [ADDR_BITS-1:0] cur_src;
  logic [ADDR_BITS-1:0] cur_dst;
  logic [ADDR_BITS-1:0] total;
  logic                 adv_first;
  logic [ADDR_BITS-1:0] ss  [MAX_RANK];
  logic [ADDR_BITS-1:0] ds  [MAX_RANK];
  logic [DIM_BITS-1:0]  idx [MAX_RANK];

  logic [DIM_BITS-1:0]  lb  [MAX_RANK];
  logic [DIM_BITS-1:0]  ub  [MAX_RANK];
  logic [DIM_BITS-1:0]  sz  [MAX_RANK];
  logic [DIM_BITS-1:0]  ext [MAX_RANK];

  logic                 cfg_err;
  logic                 cfg_empty;
  logic [RANK_W-1:0]    rank_m1;
  logic [RANK_W-1:0]    rl_w;
  logic                 d_at_top;
  logic [DIDX_W-1:0]    d_m1;
  logic                 last_flag;
  logic                 can_inc;
  logic                 slot_free;
  logic                 load_rsp;
  logic [EB_W-1:0]      eb_m1;
  logic [ADDR_BITS-1:0] c_src;
  logic [ADDR_BITS-1:0] eb_addr;

  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;
  assign rank_m1   = cfg.rank - 1'b1;
  assign d_at_top  = (RANK_W'(d) == rank_m1);
  assign d_m1      = d - 1'b1;
  assign eb_m1     = cfg.elem_bytes - 1'b1;
  assign eb_addr   = {{(ADDR_BITS-EB_W){1'b0}}, cfg.elem_bytes};
  assign can_inc   = ({1'b0, idx[d]} + 1'b1) < {1'b0, ub[d]};
  assign c_src     = (!adv_first && alu_res.valid) ? alu_res.val : cur_src;

  // Bounds checks and the outermost dimension below which everything is taken whole.
  always_comb begin
    cfg_err   = (int'(cfg.rank) > MAX_RANK) || (cfg.elem_bytes == '0);
    cfg_empty = 1'b0;
    for (int k = 0; k < MAX_RANK; k++) begin
      lb[k]  = dim_field(cfg.lower, k);
      ub[k]  = dim_field(cfg.upper, k);
      sz[k]  = dim_field(cfg.dim_sizes, k);
      ext[k] = ub[k] - lb[k];
      if (k < int'(cfg.rank)) begin
        if (lb[k] > ub[k] || ub[k] > sz[k]) begin
          cfg_err = 1'b1;
        end
        if (lb[k] == ub[k]) begin
          cfg_empty = 1'b1;
        end
      end
    end
    rl_w = (cfg.rank != '0) ? rank_m1 : '0;
    for (int k = MAX_RANK - 1; k >= 1; k--) begin
      if (int'(rl_w) == k && lb[k] == '0 && ub[k] == sz[k]) begin
        rl_w = RANK_W'(k - 1);
      end
    end
  end

  always_comb begin
    last_flag = 1'b1;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (k < int'(run_level) && ({1'b0, idx[k]} + 1'b1) != {1'b0, ub[k]}) begin
        last_flag = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_req    = '0;
    alu_req.op = OP_MAC;
    load_rsp   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ACT_START) ? S_CHECK : S_EMIT;
        end
      end
      S_CHECK: begin
        if (cfg_err || cfg_empty) begin
          state_next = S_EMIT;
        end else if (cfg.rank == '0) begin
          state_next = S_HIB;
        end else begin
          state_next = S_STA;
        end
      end
      S_STA: begin
        alu_req.valid = 1'b1;
        alu_req.a     = ds[d];
        alu_req.b     = ext[d];
        state_next    = S_STB;
      end
      S_STB: begin
        if (d != '0) begin
          alu_req.valid = 1'b1;
          alu_req.a     = ss[d];
          alu_req.b     = sz[d];
          state_next    = S_STA;
        end else begin
          state_next = S_HIB;
        end
      end
      S_HIB: begin
        // The highest source byte starts as base plus the last byte of one element.
        alu_req.valid = 1'b1;
        alu_req.a     = {{(ADDR_BITS-EB_W){1'b0}}, eb_m1};
        alu_req.b     = DIM_BITS'(1);
        alu_req.c     = sbase;
        state_next    = (cfg.rank == '0) ? S_HIEND : S_HIA;
      end
      S_HIA: begin
        alu_req.valid = 1'b1;
        alu_req.a     = ss[d];
        alu_req.b     = ub[d] - 1'b1;
        alu_req.c     = alu_res.val;
        if (d_at_top) begin
          state_next = S_HIEND;
        end
      end
      S_HIEND: begin
        if (cfg.rank == '0) begin
          alu_req.valid = 1'b1;
          alu_req.a     = total - 1'b1;
          alu_req.b     = DIM_BITS'(1);
          alu_req.c     = dbase;
          state_next    = S_DEND;
        end else begin
          state_next = S_OFA;
        end
      end
      S_OFA: begin
        alu_req.valid = 1'b1;
        alu_req.a     = ss[d];
        alu_req.b     = lb[d];
        alu_req.c     = (d == '0) ? sbase : alu_res.val;
        if (d_at_top) begin
          state_next = S_OFEND;
        end
      end
      S_OFEND: begin
        alu_req.valid = 1'b1;
        alu_req.a     = total - 1'b1;
        alu_req.b     = DIM_BITS'(1);
        alu_req.c     = dbase;
        state_next    = S_DEND;
      end
      S_DEND: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load_rsp = 1'b1;
          if (code == ST_RUN && !last_flag) begin
            alu_req.valid = 1'b1;
            alu_req.a     = run_length;
            alu_req.b     = DIM_BITS'(1);
            alu_req.c     = cur_dst;
            state_next    = S_CARRY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CARRY: begin
        alu_req.valid = 1'b1;
        alu_req.a     = ss[d];
        alu_req.c     = c_src;
        if (can_inc) begin
          alu_req.b  = DIM_BITS'(1);
          state_next = S_SRCEND;
        end else begin
          // Wrap this dimension back to its lower bound and carry outward.
          alu_req.op = OP_MSUB;
          alu_req.b  = idx[d] - lb[d];
        end
      end
      S_SRCEND: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cfg_we) begin
      active <= 1'b0;
    end else if (state == S_IDLE && req_valid && req.action == ACT_START) begin
      active <= 1'b0;
    end else if (state == S_DEND) begin
      active <= !(ovf || alu_res.ovf);
    end else if (state == S_EMIT && slot_free && code == ST_RUN && last_flag) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          sbase <= req.source_base;
          dbase <= req.dest_base;
          code  <= active ? ST_RUN : ST_NORUN;
        end
      end
      S_CHECK: begin
        ovf        <= 1'b0;
        total      <= eb_addr;
        run_length <= eb_addr;
        run_level  <= rl_w[DIDX_W-1:0];
        d          <= rank_m1[DIDX_W-1:0];
        if (cfg_err) begin
          code <= ST_ERROR;
        end else if (cfg_empty) begin
          code <= ST_NORUN;
        end
        if (cfg.rank != '0) begin
          ss[rank_m1[DIDX_W-1:0]] <= eb_addr;
          ds[rank_m1[DIDX_W-1:0]] <= eb_addr;
        end
      end
      S_STA: begin
        if (alu_res.valid) begin
          ss[d] <= alu_res.val;
          ovf   <= ovf || alu_res.ovf;
        end
      end
      S_STB: begin
        ovf <= ovf || alu_res.ovf;
        if (d == run_level) begin
          run_length <= alu_res.val;
        end
        if (d != '0) begin
          ds[d_m1] <= alu_res.val;
          d        <= d_m1;
        end else begin
          total <= alu_res.val;
        end
      end
      S_HIB: begin
        d <= '0;
      end
      S_HIA: begin
        if (alu_res.valid) begin
          ovf <= ovf || alu_res.ovf;
        end
        d <= d_at_top ? '0 : d + 1'b1;
      end
      S_HIEND: begin
        ovf <= ovf || alu_res.ovf;
        d   <= '0;
        if (cfg.rank == '0) begin
          cur_src <= sbase;
        end
      end
      S_OFA: begin
        idx[d] <= lb[d];
        d      <= d + 1'b1;
      end
      S_OFEND: begin
        cur_src <= alu_res.val;
      end
      S_DEND: begin
        cur_dst <= dbase;
        code    <= (ovf || alu_res.ovf) ? ST_ERROR : ST_NORUN;
      end
      S_EMIT: begin
        if (slot_free && code == ST_RUN && !last_flag) begin
          d         <= run_level - 1'b1;
          adv_first <= 1'b1;
        end
      end
      S_CARRY: begin
        adv_first <= 1'b0;
        if (adv_first) begin
          cur_dst <= alu_res.val;
        end else if (alu_res.valid) begin
          cur_src <= alu_res.val;
        end
        if (can_inc) begin
          idx[d] <= idx[d] + 1'b1;
        end else begin
          idx[d] <= lb[d];
          d      <= d_m1;
        end
      end
      S_SRCEND: begin
        cur_src <= alu_res.val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status <= code;
      if (code == ST_RUN) begin
        rsp.run_source <= cur_src;
        rsp.run_dest   <= cur_dst;
        rsp.run_bytes  <= run_length;
        rsp.last_run   <= last_flag;
      end else begin
        rsp.run_source <= '0;
        rsp.run_dest   <= '0;
        rsp.run_bytes  <= '0;
        rsp.last_run   <= 1'b0;
      end
    end
  end

  `HRAG_ASSERT(a_rsp_no_overwrite, load_rsp && rsp_valid, rsp_ready, "result register overwritten before its transaction completed")
  `HRAG_ASSERT(a_quiet_fields_zero, rsp_valid && rsp.status != ST_RUN, rsp.run_bytes == '0 && !rsp.last_run, "non-run result carries run fields")
  `HRAG_ASSERT(a_run_not_empty, rsp_valid && rsp.status == ST_RUN, rsp.run_bytes != '0, "issued run has zero length")
  `HRAG_ASSERT_NEXT(a_cfg_write_idles, cfg_we, !active, "register write did not abort the slice")

endmodule

[rtl/hyperslab_run_address_generator_unit.sv]
// Hyperslab run address generator: a start transaction has the shared multiply-add unit find
// the strides, up to two operations per dimension, then the highest source byte and start
// offset from the bounds; rank zero skips the per-dimension steps, bad bounds or an empty box
// go straight to the result. Next-run transaction: the result is issued, and the block is
// ready again once wrapping dimensions carry, one step per cycle on that unit, none on the last run.
// Synchronous active-high reset: configuration registers take defaults; the block comes up idle.
`timescale 1ns / 1ps

module hyperslab_run_address_generator_unit import hrag_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  cfg_t     cfg;
  logic     cfg_we;
  alu_req_t alu_req;
  alu_res_t alu_res;

  hrag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_we  (cfg_we)
  );

  hrag_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .res (alu_res)
  );

  hrag_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_we    (cfg_we),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .alu_req   (alu_req),
    .alu_res   (alu_res)
  );

endmodule
